// ----- src/ncofs_pkg.sv -----
// ----------------------------------------------------------------------------
// ncofs_pkg
// Shared constants and word types for the complex NCO frequency shifter.
// ----------------------------------------------------------------------------
package ncofs_pkg;

  // Sample and phase widths
  localparam int IN_W    = 16;
  localparam int PHASE_W = 32;

  // Quarter-wave sine table geometry and coefficient precision
  localparam int SINE_TABLE_BITS = 10;
  localparam int COEF_BITS       = 16;
  localparam int TBL_N           = 1 << SINE_TABLE_BITS;

  // Phase bits kept per sample: quadrant plus table index
  localparam int PIDX_W = SINE_TABLE_BITS + 2;

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input word
  typedef struct packed {
    logic signed [IN_W-1:0] in_real;
    logic signed [IN_W-1:0] in_imag;
    logic                   block_start;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic signed [IN_W-1:0] out_real;
    logic signed [IN_W-1:0] out_imag;
  } out_word_t;

  // Queue entry: sample plus the truncated phase it is rotated by
  typedef struct packed {
    logic signed [IN_W-1:0] re;
    logic signed [IN_W-1:0] im;
    logic [PIDX_W-1:0]      pidx;
  } q_entry_t;

endpackage

// ----- src/ncofs_front.sv -----
// ----------------------------------------------------------------------------
// ncofs_front
// Accepts sample words, holds the phase step and the phase accumulator, and
// tags each sample with the phase it is to be rotated by.
// ----------------------------------------------------------------------------
module ncofs_front
  import ncofs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic signed [PHASE_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_word_t                  in_word,
  input  logic                      q_full,
  output logic                      push,
  output q_entry_t                  push_data
);

  logic [PHASE_W-1:0] phase_step;
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] phase_cur;

  // Stall only when the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Block start rotates by phase zero
  assign phase_cur = in_word.block_start ? '0 : phase_acc;

  assign push_data.re   = in_word.in_real;
  assign push_data.im   = in_word.in_imag;
  assign push_data.pidx = phase_cur[PHASE_W-1 -: PIDX_W];

  // Step register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
    end else if (cfg_valid) begin
      phase_step <= cfg_data;
    end
  end

  // Accumulator advances once per accepted word, modulo 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (push) begin
      phase_acc <= phase_cur + phase_step;
    end
  end

endmodule

// ----- src/ncofs_queue.sv -----
// ----------------------------------------------------------------------------
// ncofs_queue
// Short register queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module ncofs_queue
  import ncofs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output q_entry_t pop_data
);

  q_entry_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_pop    = pop && pop_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/ncofs_back.sv -----
// ----------------------------------------------------------------------------
// ncofs_back
// Rotation pipeline: sine/cosine lookup, complex multiply, rounding and
// saturation, ending in the output register.
// ----------------------------------------------------------------------------
module ncofs_back
  import ncofs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  q_entry_t  q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int MAG_W  = COEF_BITS - 1;
  localparam int ADDR_W = SINE_TABLE_BITS + 1;
  localparam int PROD_W = IN_W + COEF_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RM_W   = SUM_W - (COEF_BITS - 1);

  localparam logic [63:0]     COEF_MAX = (64'd1 << (COEF_BITS - 1)) - 64'd1;
  localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (COEF_BITS - 2);
  localparam logic [RM_W-1:0]  POS_LIM  = RM_W'((1 << (IN_W - 1)) - 1);
  localparam logic [RM_W-1:0]  NEG_LIM  = RM_W'(1 << (IN_W - 1));

  typedef logic [MAG_W-1:0] rom_t [0:TBL_N];

  // One quarter-wave entry: Q30 Taylor series to the x^15 term
  function automatic logic [MAG_W-1:0] sine_entry(input logic [ADDR_W-1:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    x    = (64'd1686629713 * 64'(k) + 64'(TBL_N / 2)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    e = (sum * COEF_MAX + (64'd1 << 29)) >> 30;
    if (e > COEF_MAX) begin
      e = COEF_MAX;
    end
    return e[MAG_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= TBL_N; k++) begin
      r[k] = sine_entry(ADDR_W'(k));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Stage valids and advance enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5 = !out_valid || !out_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = q_valid && en1;

  // Table addressing: sine at the phase, cosine a quarter turn ahead
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [ADDR_W-1:0]          addr_fwd;
  logic [ADDR_W-1:0]          addr_rev;
  logic [ADDR_W-1:0]          s_addr;
  logic [ADDR_W-1:0]          c_addr;
  logic [1:0]                 quad_c;

  assign quad     = q_data.pidx[PIDX_W-1 -: 2];
  assign idx      = q_data.pidx[SINE_TABLE_BITS-1:0];
  assign quad_c   = quad + 2'd1;
  assign addr_fwd = {1'b0, idx};
  assign addr_rev = ADDR_W'(TBL_N) - addr_fwd;
  assign s_addr   = quad[0] ? addr_rev : addr_fwd;
  assign c_addr   = quad[0] ? addr_fwd : addr_rev;

  // Stage 1: table read
  logic [MAG_W-1:0]       s_mag, c_mag;
  logic                   s_neg, c_neg;
  logic signed [IN_W-1:0] re1, im1;

  always_ff @(posedge clk) begin
    if (en1) begin
      s_mag <= SINE_ROM[s_addr];
      c_mag <= SINE_ROM[c_addr];
      s_neg <= quad[1];
      c_neg <= quad_c[1];
      re1   <= q_data.re;
      im1   <= q_data.im;
    end
  end

  // Stage 2: four products
  logic signed [COEF_BITS-1:0] s_coef, c_coef;
  logic signed [PROD_W-1:0]    p_rc, p_is, p_rs, p_ic;

  assign s_coef = s_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  assign c_coef = c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

  always_ff @(posedge clk) begin
    if (en2) begin
      p_rc <= re1 * c_coef;
      p_is <= im1 * s_coef;
      p_rs <= re1 * s_coef;
      p_ic <= im1 * c_coef;
    end
  end

  // Stage 3: product sums
  logic signed [SUM_W-1:0] sum_r, sum_i;

  always_ff @(posedge clk) begin
    if (en3) begin
      sum_r <= SUM_W'(p_rc) - SUM_W'(p_is);
      sum_i <= SUM_W'(p_rs) + SUM_W'(p_ic);
    end
  end

  // Stage 4: round magnitude to nearest, halves away from zero
  logic [SUM_W-1:0] mag_r, mag_i;
  logic [SUM_W-1:0] rsum_r, rsum_i;
  logic [RM_W-1:0]  rm_r, rm_i;
  logic             neg_r, neg_i;

  assign mag_r  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign mag_i  = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign rsum_r = mag_r + RND_HALF;
  assign rsum_i = mag_i + RND_HALF;

  always_ff @(posedge clk) begin
    if (en4) begin
      rm_r  <= rsum_r[SUM_W-1 -: RM_W];
      rm_i  <= rsum_i[SUM_W-1 -: RM_W];
      neg_r <= sum_r[SUM_W-1];
      neg_i <= sum_i[SUM_W-1];
    end
  end

  // Stage 5: saturate, restore sign, output register
  function automatic logic signed [IN_W-1:0] sat(input logic [RM_W-1:0] rm,
                                                 input logic neg);
    logic [RM_W-1:0] v;
    v = neg ? -rm : rm;
    if (!neg && rm > POS_LIM) begin
      return IN_W'(POS_LIM);
    end else if (neg && rm > NEG_LIM) begin
      return IN_W'(-NEG_LIM);
    end
    return v[IN_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en5) begin
      out_word.out_real <= sat(rm_r, neg_r);
      out_word.out_imag <= sat(rm_i, neg_i);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= q_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

endmodule

// ----- src/complex_nco_frequency_shifter_unit.sv -----
// ----------------------------------------------------------------------------
// complex_nco_frequency_shifter_unit
// Rotates complex 16-bit samples by a programmable frequency offset.
// ----------------------------------------------------------------------------
// One complex sample word is accepted per clock and one rotated word leaves
// per clock while no stall holds the flow. The rate is set by the two-port
// read of the 1025-entry quarter-wave sine table, done once per word, feeding
// four 16 x 16 multipliers in the following stage. Write phase_step on the
// cfg channel (always ready) while no words are in flight; block_start makes
// a word use phase zero and restarts the accumulator from there. Output stall
// backs up through a five-stage pipeline and a four-word queue before the
// input stalls.
module complex_nco_frequency_shifter_unit
  import ncofs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_word_t                  in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_word_t                 out_word,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic signed [PHASE_W-1:0] cfg_data
);

  logic     push, q_full, pop, q_valid;
  q_entry_t push_data, q_data;

  assign cfg_ready = 1'b1;

  // Front: accept and phase-tag
  ncofs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue
  ncofs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // Back: rotation pipeline
  ncofs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ----- src/ncofs_checker.sv -----
// ----------------------------------------------------------------------------
// ncofs_checker
// Port-level checks for the frequency shifter, bound to the top level.
// ----------------------------------------------------------------------------
module ncofs_checker
  import ncofs_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input out_word_t                 out_word,
  input logic                      cfg_ready
);

  // Reset leaves no word on the output and room at the input
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  // Input backs up only after the output has been held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // Held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // Config channel never refuses a word
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

endmodule

bind complex_nco_frequency_shifter_unit ncofs_checker u_checker (.*);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex NCO frequency shifter. A clocked driver
// feeds sample words from a pending queue, a clocked monitor compares every
// rotated word against a bit-exact model of the phase accumulator, the
// quarter-wave sine table and the round/saturate stage. Phases change the
// phase step (extremes included) and the idle/stall pattern, and one phase
// holds the output off long enough to back the pipeline up to the input.
// ----------------------------------------------------------------------------
module tb;
  import ncofs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT      = 200000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int SHOW_MAX       = 10;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  in_word_t                  in_word   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_word_t                 out_word;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic signed [PHASE_W-1:0] cfg_data  = '0;

  complex_nco_frequency_shifter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Model state
  int           qsin [TBL_N+1];
  logic [31:0]  nco_phase = '0;
  logic [31:0]  nco_step  = '0;

  in_word_t     pending_words [$];
  out_word_t    expected_rot [$];
  out_word_t    oldest_rot;

  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  bit           hold_req      = 1'b0;
  bit           hold_done     = 1'b0;
  int           hold_cnt      = 0;
  int           mismatches    = 0;
  int           cycle_count   = 0;

  // Quarter-wave table entry: Q30 Taylor series, truncated products
  function automatic int sine_entry_calc(int unsigned k);
    longint unsigned x, x2, term, sum, e, amax;
    amax = (64'd1 << (COEF_BITS - 1)) - 64'd1;
    x    = (64'd1686629713 * k + 64'(TBL_N >> 1)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int unsigned i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i[0]) sum = sum - term;
      else      sum = sum + term;
    end
    e = (sum * amax + (64'd1 << 29)) >> 30;
    if (e > amax) e = amax;
    return int'(e);
  endfunction

  // Signed sine of a 32-bit phase from the quarter table
  function automatic longint sine_at(logic [31:0] p);
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    longint                     v;
    quad = p[31:30];
    idx  = p[29 -: SINE_TABLE_BITS];
    v    = quad[0] ? longint'(qsin[TBL_N - int'(idx)]) : longint'(qsin[idx]);
    return quad[1] ? -v : v;
  endfunction

  // Round half away from zero, drop COEF_BITS-1 fraction bits, saturate
  function automatic logic [15:0] round_sat(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (COEF_BITS - 2))) >> (COEF_BITS - 1);
    if (v < 0) mag = -mag;
    if (mag > 32767)  mag = 32767;
    if (mag < -32768) mag = -32768;
    return mag[15:0];
  endfunction

  // Expected rotated word; advances the model accumulator
  function automatic out_word_t rotate_sample(in_word_t w);
    logic [31:0] p;
    longint      re, im, sn, cs;
    out_word_t   r;
    re = longint'($signed(w.in_real));
    im = longint'($signed(w.in_imag));
    p  = w.block_start ? 32'd0 : nco_phase;
    sn = sine_at(p);
    cs = sine_at(p + 32'h4000_0000);
    r.out_real = round_sat(re * cs - im * sn);
    r.out_imag = round_sat(re * sn + im * cs);
    nco_phase  = p + nco_step;
    return r;
  endfunction

  // Random sample word: mostly full-range, some extremes, occasional block start
  function automatic in_word_t random_sample();
    in_word_t w;
    logic [15:0] corner [4];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    w.in_real     = ($urandom_range(99) < 15) ? corner[$urandom_range(3)] : 16'($urandom);
    w.in_imag     = ($urandom_range(99) < 15) ? corner[$urandom_range(3)] : 16'($urandom);
    w.block_start = ($urandom_range(9) == 0);
    return w;
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Long output hold-off, counted here, started once on request
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // Driver: predict on accept, then offer the next word or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_rot.push_back(rotate_sample(in_word));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_rot.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < SHOW_MAX)
          $display("unexpected output word re=%0d im=%0d",
                   $signed(out_word.out_real), $signed(out_word.out_imag));
      end else begin
        oldest_rot = expected_rot.pop_front();
        if (out_word.out_real !== oldest_rot.out_real ||
            out_word.out_imag !== oldest_rot.out_imag) begin
          mismatches <= mismatches + 1;
          if (mismatches < SHOW_MAX)
            $display("rotation mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                     $signed(oldest_rot.out_real), $signed(oldest_rot.out_imag),
                     $signed(out_word.out_real), $signed(out_word.out_imag));
        end
      end
    end
  end

  task automatic push_sample(logic [15:0] re, logic [15:0] im, bit bs);
    in_word_t w;
    w.in_real     = re;
    w.in_imag     = im;
    w.block_start = bs;
    pending_words.push_back(w);
  endtask

  // Wait until every queued word is sent and every result seen
  task automatic wait_drain();
    while (pending_words.size() != 0 || in_valid || expected_rot.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write while the block is idle
  task automatic write_phase_step(logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    nco_step = v;
  endtask

  task automatic run_phase(logic [31:0] step, int n, int s_idle, int r_stall, bit hold);
    wait_drain();
    write_phase_step(step);
    send_idle_pct = s_idle;
    stall_pct     = r_stall;
    if (hold) hold_req = 1'b1;
    pending_words.push_back(random_sample());
    pending_words[0].block_start = 1'b1;
    for (int i = 1; i < n; i++) pending_words.push_back(random_sample());
  endtask

  initial begin
    for (int k = 0; k <= TBL_N; k++) qsin[k] = sine_entry_calc(k);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: eighth-turn step walks all octants; extremes and overflow
    write_phase_step(32'h2000_0000);
    push_sample(16'h7FFF, 16'h0000, 1'b1);
    push_sample(16'h7FFF, 16'h8000, 1'b0);   // saturates real part
    push_sample(16'h8000, 16'h8000, 1'b0);
    push_sample(16'h8000, 16'h7FFF, 1'b0);
    push_sample(16'h7FFF, 16'h7FFF, 1'b0);
    push_sample(16'h8000, 16'h8000, 1'b0);   // saturates imag part
    push_sample(16'h0000, 16'h0000, 1'b0);
    push_sample(16'hFFFF, 16'hFFFF, 1'b0);
    push_sample(16'h0001, 16'h0001, 1'b0);
    push_sample(16'h8000, 16'h8000, 1'b1);   // phase zero: no overflow
    push_sample(16'h8000, 16'h8000, 1'b0);
    push_sample(16'h7FFF, 16'h7FFF, 1'b0);
    push_sample(16'h5555, 16'hAAAA, 1'b0);
    push_sample(16'hAAAA, 16'h5555, 1'b1);
    push_sample(16'h7FFF, 16'h8000, 1'b0);
    push_sample(16'h8000, 16'h7FFF, 1'b0);
    push_sample(16'h0001, 16'hFFFF, 1'b0);
    push_sample(16'hFFFF, 16'h0001, 1'b0);
    push_sample(16'h4000, 16'hC000, 1'b0);

    // Accumulator wrap at extreme steps, various idle patterns
    run_phase(32'h7FFF_FFFF, 100, 78, 0, 1'b0);
    run_phase(32'h8000_0000, 100, 0, 78, 1'b0);
    run_phase(32'hFFFF_FFFF, 100, 7, 7, 1'b0);
    run_phase(32'h0000_0001, 100, 0, 0, 1'b0);
    // Back-pressure: output held off while input keeps offering
    run_phase($urandom, 80, 0, 0, 1'b1);
    run_phase($urandom, 120, 7, 7, 1'b0);
    run_phase(32'h0000_0000, 100, 0, 78, 1'b0);

    wait_drain();
    if (mismatches == 0 && expected_rot.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
